>>> design/hss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types, opcodes, weight table and score scaling constants for the
// Haar signature similarity score unit.
// ----------------------------------------------------------------------------
package hss_pkg;

  // image side as a power of two, bins use |i| mod / div side
  localparam int SIDE_LOG2   = 7;
  localparam int SIDE_PIXELS = 1 << SIDE_LOG2;

  localparam int MAX_COEFS = 40;
  localparam int NUM_CH    = 3;
  localparam int MEM_DEPTH = NUM_CH * MAX_COEFS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CNT_W     = $clog2(MAX_COEFS + 1);

  localparam int OP_W   = 3;
  localparam int CH_W   = 2;
  localparam int IDX_W  = 15;
  localparam int AVG_W  = 16;
  localparam int SIM_W  = 15;
  localparam int ACC_W  = 40;
  localparam int WGT_W  = 12;
  localparam int DIFF_W = 16;
  localparam int TERM_W = 28;
  localparam int BIN_W  = 3;
  localparam int CREDIT_SHIFT = 15;

  localparam logic [OP_W-1:0] OP_QIDX   = 3'd0;
  localparam logic [OP_W-1:0] OP_QAVG   = 3'd1;
  localparam logic [OP_W-1:0] OP_START  = 3'd2;
  localparam logic [OP_W-1:0] OP_CIDX   = 3'd3;
  localparam logic [OP_W-1:0] OP_CAVG   = 3'd4;
  localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

  localparam logic [BIN_W-1:0] BIN_MAX = 3'd5;

  // score = min(SCORE_MAX, floor((10*n + SCORE_RND) / SCORE_DIV))
  localparam longint SCORE_MAX = 25600;
  localparam longint SCORE_RND = 24768;
  localparam longint SCORE_DIV = 49536;
  localparam longint SCORE_MUL = 10;
  // smallest n that already clamps
  localparam longint FIN_THRESH =
    (SCORE_MAX * SCORE_DIV - SCORE_RND + SCORE_MUL - 1) / SCORE_MUL;
  localparam int N_SMALL_W = 27;   // n below the threshold fits here
  localparam int X_W       = 31;   // 10*n + rounding below the threshold

  // SCORE_DIV = 387 << 7: shift by 7, then multiply by ceil(2^32 / 387)
  localparam int DIV_SHIFT   = 7;
  localparam int Y_W         = X_W - DIV_SHIFT;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = Y_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd11098107;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } hss_state_t;

  typedef enum logic [2:0] {
    FIN_IDLE,
    FIN_NEG,
    FIN_SCALE,
    FIN_DIV,
    FIN_DONE
  } hss_fin_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } hss_fin_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hss_fin_sts_t;

  // weights times 100, by bin and channel
  function automatic logic [WGT_W-1:0] weight(input logic [BIN_W-1:0] bin,
                                              input logic [CH_W-1:0] ch);
    logic [WGT_W-1:0] w;
    w = '0;
    unique case (bin)
      3'd0: w = (ch == 2'd0) ? 12'd500 : (ch == 2'd1) ? 12'd1921 : 12'd3437;
      3'd1: w = (ch == 2'd0) ? 12'd83  : (ch == 2'd1) ? 12'd126  : 12'd36;
      3'd2: w = (ch == 2'd0) ? 12'd101 : (ch == 2'd1) ? 12'd44   : 12'd45;
      3'd3: w = (ch == 2'd0) ? 12'd52  : (ch == 2'd1) ? 12'd53   : 12'd14;
      3'd4: w = (ch == 2'd0) ? 12'd47  : (ch == 2'd1) ? 12'd28   : 12'd18;
      default: w = (ch == 2'd0) ? 12'd30 : (ch == 2'd1) ? 12'd14 : 12'd27;
    endcase
    return w;
  endfunction

endpackage

>>> design/hss_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_finish
// Turns the signed accumulator into the clamped 7.8 similarity score: scale
// by ten, then divide by the fixed divisor with a shift and a reciprocal
// multiply.
// ----------------------------------------------------------------------------
module hss_finish
  import hss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  hss_fin_ctl_t            ctl,
  input  logic signed [ACC_W-1:0] acc,
  output hss_fin_sts_t            sts,
  output logic [SIM_W-1:0]        similarity
);

  hss_fin_state_t state_r, state_nxt;
  logic [ACC_W-1:0]  n_r, n_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [SIM_W-1:0]  q_r, q_nxt;
  logic [PROD_W-1:0] prod;

  // exact floor for every x below the clamp threshold
  assign prod = PROD_W'(x_r[X_W-1:DIV_SHIFT]) * PROD_W'(RECIP_MUL);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FIN_IDLE:  if (ctl.start) state_nxt = FIN_NEG;
      FIN_NEG:   state_nxt = acc[ACC_W-1] ? FIN_SCALE : FIN_DONE;
      FIN_SCALE: state_nxt = (n_r >= ACC_W'(FIN_THRESH)) ? FIN_DONE : FIN_DIV;
      FIN_DIV:   state_nxt = FIN_DONE;
      FIN_DONE:  if (ctl.ack) state_nxt = FIN_IDLE;
      default:   state_nxt = FIN_IDLE;
    endcase
  end

  always_comb begin
    n_nxt = n_r;
    x_nxt = x_r;
    q_nxt = q_r;
    unique case (state_r)
      FIN_NEG: begin
        n_nxt = ACC_W'(-acc);
        q_nxt = '0;
      end
      FIN_SCALE: begin
        if (n_r >= ACC_W'(FIN_THRESH)) begin
          q_nxt = SIM_W'(SCORE_MAX);
        end else begin
          x_nxt = X_W'(n_r[N_SMALL_W-1:0]) * X_W'(SCORE_MUL) + X_W'(SCORE_RND);
        end
      end
      FIN_DIV: begin
        q_nxt = prod[RECIP_SHIFT +: SIM_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FIN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r <= n_nxt;
    x_r <= x_nxt;
    q_r <= q_nxt;
  end

  assign sts.busy   = (state_r != FIN_IDLE);
  assign sts.done   = (state_r == FIN_DONE);
  assign similarity = q_r;

endmodule

>>> design/haar_signature_similarity_score_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haar_signature_similarity_score_unit
// Stores a query Haar signature and scores a streamed candidate against it.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          word
//  in_      input      in_valid/in_stall  opcode, channel, coef_index, average
//  out_     output     out_valid/out_stall similarity on finish
//
// one word at a time; in_stall is high while a word is being worked on.
// index words scan the query memory one entry a cycle; a candidate index
// that is found is then credited.
// candidate average words multiply, then accumulate; finish needs a free out_.
// reset clears counts, averages and accumulator; the index memory needs none.
// the result sits in an output register, so a stalled out_ only holds a
// following finish word, everything else keeps flowing.
// ----------------------------------------------------------------------------
module haar_signature_similarity_score_unit
  import hss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic [CH_W-1:0]         in_channel,
  input  logic signed [IDX_W-1:0] in_coef_index,
  input  logic signed [AVG_W-1:0] in_channel_average,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SIM_W-1:0]        out_similarity
);

  hss_state_t state_r, state_nxt;

  logic [IDX_W-1:0] qmem [0:MEM_DEPTH-1];
  logic [IDX_W-1:0] mem_q;
  logic             mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  logic [CNT_W-1:0]        cnt_r [NUM_CH];
  logic [CNT_W-1:0]        cnt_nxt [NUM_CH];
  logic signed [AVG_W-1:0] qavg_r [NUM_CH];
  logic signed [AVG_W-1:0] qavg_nxt [NUM_CH];
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [CH_W-1:0]   c_r, c_nxt;
  logic [IDX_W-1:0]  pat_r, pat_nxt;
  logic [BIN_W-1:0]  bin_r, bin_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              hit_r, hit_nxt;
  logic              rdv_r, rdv_nxt;
  logic [DIFF_W-1:0] diff_r, diff_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic              neg_r, neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SIM_W-1:0]  out_sim_r, out_sim_nxt;

  hss_fin_ctl_t     fin_ctl;
  hss_fin_sts_t     fin_sts;
  logic [SIM_W-1:0] fin_sim;

  // input decode
  logic                  in_take, ch_ok;
  logic [CH_W-1:0]       ch_ix;
  logic [CNT_W-1:0]      cnt_in;
  logic                  qidx_ok, cidx_ok, cavg_ok;
  logic                  go_scan, go_apply, go_mul, go_fin;
  logic [IDX_W-1:0]      mag;
  logic [IDX_W-1:0]      rem_part, quo_part, bin_max;
  logic [BIN_W-1:0]      bin_in;
  logic [ADDR_W-1:0]     base_in;
  logic signed [AVG_W:0] d17;

  // scan and accumulate
  logic              issue, hit_now, out_free;
  logic [ACC_W:0]    sum41, tz;

  always_comb begin
    in_take = in_valid && (state_r == ST_IDLE);
    ch_ok   = (in_channel < CH_W'(NUM_CH));
    ch_ix   = ch_ok ? in_channel : '0;
    cnt_in  = cnt_r[ch_ix];
    qidx_ok = (in_opcode == OP_QIDX) && ch_ok && (cnt_in < CNT_W'(MAX_COEFS));
    cidx_ok = (in_opcode == OP_CIDX) && ch_ok && (cnt_in != '0);
    cavg_ok = (in_opcode == OP_CAVG) && ch_ok;
    go_scan  = in_take && ((qidx_ok && (cnt_in != '0)) || cidx_ok);
    go_apply = in_take && qidx_ok && (cnt_in == '0);
    go_mul   = in_take && cavg_ok;
    go_fin   = in_take && (in_opcode == OP_FINISH);

    // bin = min(max(|i| mod side, |i| div side), 5)
    mag      = in_coef_index[IDX_W-1] ? IDX_W'(-in_coef_index) : IDX_W'(in_coef_index);
    rem_part = IDX_W'(mag[SIDE_LOG2-1:0]);
    quo_part = mag >> SIDE_LOG2;
    bin_max  = (rem_part > quo_part) ? rem_part : quo_part;
    bin_in   = (bin_max > IDX_W'(BIN_MAX)) ? BIN_MAX : bin_max[BIN_W-1:0];

    unique case (ch_ix)
      2'd1:    base_in = ADDR_W'(MAX_COEFS);
      2'd2:    base_in = ADDR_W'(2 * MAX_COEFS);
      default: base_in = '0;
    endcase

    d17 = (AVG_W+1)'(in_channel_average) - (AVG_W+1)'(qavg_r[ch_ix]);
  end

  assign issue    = (k_r < lim_r);
  assign hit_now  = hit_r || (rdv_r && (mem_q == pat_r));
  assign out_free = !out_valid_r || !out_stall;
  assign tz       = (ACC_W+1)'(term_r);
  assign sum41    = neg_r ? ({acc_r[ACC_W-1], acc_r} - tz) : ({acc_r[ACC_W-1], acc_r} + tz);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        priority if (go_fin)   state_nxt = ST_FIN;
        else if (go_scan)      state_nxt = ST_SCAN;
        else if (go_apply)     state_nxt = ST_APPLY;
        else if (go_mul)       state_nxt = ST_MUL;
        else                   state_nxt = ST_IDLE;
      end
      ST_SCAN:  if (!issue && !rdv_r) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = (op_r == OP_CIDX && hit_r) ? ST_ACC : ST_IDLE;
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_IDLE;
      ST_FIN:   if (fin_sts.done && out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt  = cnt_r;
    qavg_nxt = qavg_r;
    acc_nxt  = acc_r;
    op_nxt   = op_r;
    c_nxt    = c_r;
    pat_nxt  = pat_r;
    bin_nxt  = bin_r;
    base_nxt = base_r;
    lim_nxt  = lim_r;
    k_nxt    = k_r;
    hit_nxt  = hit_r;
    rdv_nxt  = rdv_r;
    diff_nxt = diff_r;
    term_nxt = term_r;
    neg_nxt  = neg_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = base_r + ADDR_W'(lim_r);
    mem_raddr = base_r + ADDR_W'(k_r);
    fin_ctl   = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_sim_nxt   = out_sim_r;

    unique case (state_r)
      ST_IDLE: begin
        op_nxt   = in_opcode;
        c_nxt    = ch_ix;
        pat_nxt  = in_coef_index;
        bin_nxt  = bin_in;
        base_nxt = base_in;
        lim_nxt  = cnt_in;
        k_nxt    = '0;
        hit_nxt  = 1'b0;
        rdv_nxt  = 1'b0;
        diff_nxt = d17[AVG_W] ? DIFF_W'(-d17) : DIFF_W'(d17);
        if (go_fin) begin
          fin_ctl.start = 1'b1;
        end
        if (in_take && in_opcode == OP_START) begin
          acc_nxt = '0;
        end
        if (in_take && in_opcode == OP_QAVG && ch_ok) begin
          qavg_nxt[ch_ix] = in_channel_average;
        end
      end
      ST_SCAN: begin
        mem_re  = issue;
        rdv_nxt = issue;
        hit_nxt = hit_now;
        k_nxt   = k_r + CNT_W'(issue);
      end
      ST_APPLY: begin
        if (op_r == OP_QIDX) begin
          if (!hit_r) begin
            mem_we      = 1'b1;
            cnt_nxt[c_r] = lim_r + 1'b1;
          end
        end else begin
          term_nxt = TERM_W'({weight(bin_r, c_r), {CREDIT_SHIFT{1'b0}}});
          neg_nxt  = 1'b1;
        end
      end
      ST_MUL: begin
        term_nxt = TERM_W'(weight('0, c_r)) * TERM_W'(diff_r);
        neg_nxt  = 1'b0;
      end
      ST_ACC: begin
        // saturate when the top two sum bits disagree
        if (sum41[ACC_W] != sum41[ACC_W-1]) begin
          acc_nxt = sum41[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          acc_nxt = sum41[ACC_W-1:0];
        end
      end
      ST_FIN: begin
        if (fin_sts.done && out_free) begin
          fin_ctl.ack   = 1'b1;
          out_valid_nxt = 1'b1;
          out_sim_nxt   = fin_sim;
        end
      end
      default: ;
    endcase
  end

  // query index memory, reads and writes never overlap in time
  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[mem_waddr] <= pat_r;
    end
    if (mem_re) begin
      mem_q <= qmem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        cnt_r[i]  <= '0;
        qavg_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      rdv_r       <= rdv_nxt;
      cnt_r       <= cnt_nxt;
      qavg_r      <= qavg_nxt;
    end
    op_r      <= op_nxt;
    c_r       <= c_nxt;
    pat_r     <= pat_nxt;
    bin_r     <= bin_nxt;
    base_r    <= base_nxt;
    lim_r     <= lim_nxt;
    k_r       <= k_nxt;
    hit_r     <= hit_nxt;
    diff_r    <= diff_nxt;
    term_r    <= term_nxt;
    neg_r     <= neg_nxt;
    out_sim_r <= out_sim_nxt;
  end

  hss_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (fin_ctl),
    .acc        (acc_r),
    .sts        (fin_sts),
    .similarity (fin_sim)
  );

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_similarity = out_sim_r;

endmodule

>>> test/tb_haar_signature_similarity_score_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_haar_signature_similarity_score_unit
// Loads query signatures and streams candidates (directed corner words, then
// random query bursts, candidate runs and noise) under several idle/stall
// mixes. A scoreboard keeps its own query store and score accumulator and
// checks every similarity word against its prediction, in order.
// ----------------------------------------------------------------------------
module tb_haar_signature_similarity_score_unit;
  import hss_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam logic [CH_W-1:0] CH_Y    = 2'd0;
  localparam logic [CH_W-1:0] CH_I    = 2'd1;
  localparam logic [CH_W-1:0] CH_Q    = 2'd2;
  localparam logic [CH_W-1:0] CH_NONE = 2'd3;

  localparam logic [IDX_W-1:0] IDX_MOST_NEG = 15'h4000;
  localparam logic [IDX_W-1:0] IDX_MOST_POS = 15'h3fff;
  localparam logic [AVG_W-1:0] AVG_MOST_NEG = 16'h8000;
  localparam logic [AVG_W-1:0] AVG_MOST_POS = 16'h7fff;

  localparam longint ACC_HI = (64'sd1 <<< 39) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  localparam int STRETCH_WORDS  = 244;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT = 4000;

  class similarity_tracker;
    logic [IDX_W-1:0] q_idx [NUM_CH][MAX_COEFS];
    int               q_cnt [NUM_CH];
    int               q_avg [NUM_CH];
    int               credit_w [6][3];
    longint           acc;
    logic [SIM_W-1:0] pending_scores [$];
    int               errors;

    function new();
      credit_w = '{'{500, 1921, 3437}, '{83, 126, 36}, '{101, 44, 45},
                   '{52, 53, 14}, '{47, 28, 18}, '{30, 14, 27}};
      foreach (q_cnt[c]) begin
        q_cnt[c] = 0;
        q_avg[c] = 0;
      end
      acc = 0;
      errors = 0;
    endfunction

    function bit holds(int c, logic [IDX_W-1:0] pat);
      for (int k = 0; k < q_cnt[c]; k++)
        if (q_idx[c][k] == pat) return 1'b1;
      return 1'b0;
    endfunction

    function void add_sat(longint d);
      if (d > 0 && acc > ACC_HI - d) acc = ACC_HI;
      else if (d < 0 && acc < ACC_LO - d) acc = ACC_LO;
      else acc = acc + d;
    endfunction

    function logic [SIM_W-1:0] score_now();
      longint n;
      longint s;
      s = 0;
      if (acc < 0) begin
        // n / (38.7 * 128) rounded half up
        n = -acc;
        s = (n * 10 + 24768) / 49536;
        if (s > 25600) s = 25600;
      end
      return SIM_W'(s);
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                            logic [IDX_W-1:0] idx, logic [AVG_W-1:0] avg);
      int     c;
      int     mag;
      int     r;
      int     q;
      int     bin;
      longint diff;
      c = int'(ch);
      if (op == OP_FINISH) begin
        pending_scores = {pending_scores, score_now()};
        return;
      end
      if (op == OP_START) begin
        acc = 0;
        return;
      end
      if (ch == CH_NONE || op == OP_SPARE_A || op == OP_SPARE_B) return;
      case (op)
        OP_QIDX: begin
          if (q_cnt[c] < MAX_COEFS && !holds(c, idx)) begin
            q_idx[c][q_cnt[c]] = idx;
            q_cnt[c]++;
          end
        end
        OP_QAVG: q_avg[c] = int'($signed(avg));
        OP_CIDX: begin
          if (holds(c, idx)) begin
            mag = int'($signed(idx));
            if (mag < 0) mag = -mag;
            r = mag % SIDE_PIXELS;
            q = mag / SIDE_PIXELS;
            bin = (r > q) ? r : q;
            if (bin > 5) bin = 5;
            add_sat(-(longint'(credit_w[bin][c]) * 32768));
          end
        end
        OP_CAVG: begin
          diff = longint'($signed(avg)) - longint'(q_avg[c]);
          if (diff < 0) diff = -diff;
          add_sat(longint'(credit_w[0][c]) * diff);
        end
        default: ;
      endcase
    endfunction

    function void check_score(logic [SIM_W-1:0] got);
      logic [SIM_W-1:0] want;
      if (pending_scores.size() == 0) begin
        errors++;
        if (errors < 50)
          $display("%0t: similarity mismatch, expected none, got %0d", $time, got);
        return;
      end
      want = pending_scores.pop_front();
      if (got !== want) begin
        errors++;
        if (errors < 50)
          $display("%0t: similarity mismatch, expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return pending_scores.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode = '0;
  logic [CH_W-1:0]   in_channel = '0;
  logic [IDX_W-1:0]  in_coef_index = '0;
  logic [AVG_W-1:0]  in_channel_average = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SIM_W-1:0]  out_similarity;

  similarity_tracker sb = new();

  int idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;

  haar_signature_similarity_score_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_channel        (in_channel),
    .in_coef_index     (in_coef_index),
    .in_channel_average(in_channel_average),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_similarity    (out_similarity)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: one long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall)
        sb.note_word(in_opcode, in_channel, in_coef_index, in_channel_average);
      if (out_valid && !out_stall)
        sb.check_score(out_similarity);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_haar_signature_similarity_score_unit NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                           input logic [IDX_W-1:0] idx, input logic [AVG_W-1:0] avg);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_channel <= ch;
    in_coef_index <= idx;
    in_channel_average <= avg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(0, 9) == 0) return CH_NONE;
    return CH_W'($urandom_range(0, 2));
  endfunction

  function automatic logic [IDX_W-1:0] gen_coef();
    int mag;
    case ($urandom_range(0, 3))
      0, 1: begin
        // low bins: both row and column position near the origin
        mag = $urandom_range(0, 5) * SIDE_PIXELS + $urandom_range(0, 5);
        return IDX_W'($urandom_range(0, 1) ? -mag : mag);
      end
      2: return IDX_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return IDX_MOST_NEG;
          1: return IDX_MOST_POS;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] cand_coef(logic [CH_W-1:0] ch);
    logic [IDX_W-1:0] v;
    if (ch != CH_NONE && sb.q_cnt[ch] > 0 && $urandom_range(0, 9) < 6) begin
      v = sb.q_idx[ch][$urandom_range(0, sb.q_cnt[ch] - 1)];
      if ($urandom_range(0, 9) == 0) v = -v;
      return v;
    end
    return gen_coef();
  endfunction

  function automatic logic [AVG_W-1:0] cand_avg(logic [CH_W-1:0] ch);
    int v;
    if (ch != CH_NONE && $urandom_range(0, 9) < 7) begin
      // near the query average so that credits can win
      v = sb.q_avg[ch] + $urandom_range(0, 200) - 100;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return AVG_W'(v);
    end
    return AVG_W'($urandom);
  endfunction

  function automatic logic [AVG_W-1:0] query_avg();
    case ($urandom_range(0, 7))
      0: return AVG_MOST_NEG;
      1: return AVG_MOST_POS;
      default: return AVG_W'($urandom);
    endcase
  endfunction

  task automatic run_query_burst();
    int n;
    logic [CH_W-1:0] c;
    n = $urandom_range(1, 12);
    repeat (n) begin
      c = pick_channel();
      if (c != CH_NONE && sb.q_cnt[c] > 0 && $urandom_range(0, 5) == 0)
        send_word(OP_QIDX, c, sb.q_idx[c][$urandom_range(0, sb.q_cnt[c] - 1)],
                  AVG_W'($urandom));
      else
        send_word(OP_QIDX, c, gen_coef(), AVG_W'($urandom));
    end
    if ($urandom_range(0, 1) == 1) begin
      c = pick_channel();
      send_word(OP_QAVG, c, IDX_W'($urandom), query_avg());
    end
  endtask

  task automatic run_candidate();
    int len;
    logic [CH_W-1:0] c;
    // now and then the start word is missing
    if ($urandom_range(0, 9) != 0)
      send_word(OP_START, CH_W'($urandom), IDX_W'($urandom), AVG_W'($urandom));
    len = $urandom_range(1, 14);
    repeat (len) begin
      c = pick_channel();
      if ($urandom_range(0, 3) == 0)
        send_word(OP_CAVG, c, IDX_W'($urandom), cand_avg(c));
      else
        send_word(OP_CIDX, c, cand_coef(c), AVG_W'($urandom));
    end
    if ($urandom_range(0, 9) != 0)
      send_word(OP_FINISH, CH_W'($urandom), IDX_W'($urandom), AVG_W'($urandom));
    if ($urandom_range(0, 7) == 0)
      send_word(OP_FINISH, CH_W'($urandom), IDX_W'($urandom), AVG_W'($urandom));
  endtask

  initial begin
    int target;
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corner words: extremes, duplicates, ignored words, clamp and zero scores
    send_word(OP_QIDX, CH_Y, '0, AVG_MOST_NEG);
    send_word(OP_QIDX, CH_Q, '0, AVG_MOST_POS);
    send_word(OP_QIDX, CH_I, IDX_MOST_NEG, '0);
    send_word(OP_QIDX, CH_I, IDX_MOST_POS, '1);
    send_word(OP_QIDX, CH_Y, '0, '0);
    send_word(OP_QIDX, CH_NONE, 15'd5, '0);
    send_word(OP_QAVG, CH_Y, IDX_MOST_POS, AVG_MOST_NEG);
    send_word(OP_QAVG, CH_Y, IDX_MOST_NEG, AVG_MOST_POS);
    send_word(OP_QAVG, CH_NONE, '0, '0);
    send_word(OP_SPARE_A, CH_Y, '0, '0);
    send_word(OP_SPARE_B, CH_Q, '1, '1);
    send_word(OP_START, CH_Y, '0, '0);
    send_word(OP_CIDX, CH_Q, '0, '0);
    send_word(OP_CIDX, CH_Q, '0, '0);
    send_word(OP_FINISH, CH_Y, '0, '0);
    send_word(OP_FINISH, CH_NONE, '1, '1);
    send_word(OP_START, CH_NONE, '0, '0);
    send_word(OP_CAVG, CH_Y, '0, AVG_MOST_NEG);
    send_word(OP_CIDX, CH_I, IDX_MOST_NEG, '0);
    send_word(OP_FINISH, CH_Q, '0, '0);
    send_word(OP_START, CH_I, '0, '0);
    send_word(OP_CIDX, CH_I, IDX_MOST_POS, '0);
    send_word(OP_CAVG, CH_NONE, '0, AVG_MOST_NEG);
    send_word(OP_FINISH, CH_Q, '0, '0);

    for (int s = 0; s < 8; s++) begin
      case (s % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      // sender waits once for every score to come back
      if (s == 1) drain();
      target = words_sent + STRETCH_WORDS;
      while (words_sent < target) begin
        // long receiver hold-off while the sender keeps offering words
        if (s == 0 && !hold_req && words_sent > target - 150) hold_req = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 15) run_query_burst();
        else if (pick < 90) run_candidate();
        else send_word(OP_W'($urandom), CH_W'($urandom), IDX_W'($urandom),
                       AVG_W'($urandom));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_haar_signature_similarity_score_unit OK");
    else
      $display("tb_haar_signature_similarity_score_unit NOT OK");
    $finish;
  end

endmodule
